// File: rtl/cau_pkg.sv
// Shared types and codes for the complex arithmetic unit.
// No dependencies; imported by cau_step and complex_arithmetic_unit_core.
package cau_pkg;

  typedef enum logic [3:0] {
    CMD_ADD  = 4'd0,
    CMD_SUB  = 4'd1,
    CMD_MUL  = 4'd2,
    CMD_DIV  = 4'd3,
    CMD_DIVS = 4'd4,
    CMD_MAG  = 4'd5,
    CMD_EQ   = 4'd6,
    CMD_NE   = 4'd7,
    CMD_NEG  = 4'd8,
    CMD_INC  = 4'd9,
    CMD_DEC  = 4'd10,
    CMD_PASS = 4'd11
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK  = 2'd0,
    ST_DZ  = 2'd1,
    ST_SAT = 2'd2
  } status_t;

  // control that travels with each request through the divide/root steps
  typedef struct packed {
    logic [3:0] cmd;
    logic       sign_re;
    logic       sign_im;
    logic       ovf_re;
    logic       ovf_im;
    logic       flag;
    logic       dz;
  } ctl_t;

endpackage

// File: rtl/cau_step.sv
// One register stage of the quotient/root pipeline: one quotient bit per lane
// for divides, one root bit for magnitude. Depends on cau_pkg.
module cau_step #(
  parameter int DATA_WIDTH = 32,
  parameter int STEP       = 0
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  cau_pkg::ctl_t             in_ctl,
  input  logic [DATA_WIDTH:0]       in_q_re,
  input  logic [DATA_WIDTH:0]       in_q_im,
  input  logic [2*DATA_WIDTH-1:0]   in_rem_re,
  input  logic [2*DATA_WIDTH-1:0]   in_rem_im,
  input  logic [2*DATA_WIDTH-1:0]   in_den,
  output logic                      out_valid,
  input  logic                      out_ready,
  output cau_pkg::ctl_t             out_ctl,
  output logic [DATA_WIDTH:0]       out_q_re,
  output logic [DATA_WIDTH:0]       out_q_im,
  output logic [2*DATA_WIDTH-1:0]   out_rem_re,
  output logic [2*DATA_WIDTH-1:0]   out_rem_im,
  output logic [2*DATA_WIDTH-1:0]   out_den
);
  import cau_pkg::*;

  localparam int W     = DATA_WIDTH;
  localparam int QW    = DATA_WIDTH + 1;
  localparam int DW    = 2 * DATA_WIDTH;
  localparam bit SQ_ON = (STEP < DATA_WIDTH);

  logic [DW:0]      t_re, t_im;
  logic             ge_re, ge_im;
  logic [DW:0]      d_re, d_im;
  logic [W+2:0]     st, trial, sd;
  logic             sge;
  logic [QW-1:0]    q_re_next, q_im_next;
  logic [DW-1:0]    rem_re_next, rem_im_next, den_next;

  always_comb begin
    t_re  = {in_rem_re, in_q_re[QW-1]};
    t_im  = {in_rem_im, in_q_im[QW-1]};
    ge_re = t_re >= {1'b0, in_den};
    ge_im = t_im >= {1'b0, in_den};
    d_re  = t_re - {1'b0, in_den};
    d_im  = t_im - {1'b0, in_den};

    // root: remainder lives in rem_re, root in q_re, radicand in den
    st    = {in_rem_re[W:0], in_den[DW-1 -: 2]};
    trial = {1'b0, in_q_re[W-1:0], 2'b01};
    sge   = st >= trial;
    sd    = sge ? (st - trial) : st;

    q_re_next   = in_q_re;
    q_im_next   = in_q_im;
    rem_re_next = in_rem_re;
    rem_im_next = in_rem_im;
    den_next    = in_den;

    if (in_ctl.cmd == CMD_DIV || in_ctl.cmd == CMD_DIVS) begin
      q_re_next   = {in_q_re[QW-2:0], ge_re};
      q_im_next   = {in_q_im[QW-2:0], ge_im};
      rem_re_next = ge_re ? d_re[DW-1:0] : t_re[DW-1:0];
      rem_im_next = ge_im ? d_im[DW-1:0] : t_im[DW-1:0];
    end else if (in_ctl.cmd == CMD_MAG && SQ_ON) begin
      q_re_next   = {1'b0, in_q_re[W-2:0], sge};
      rem_re_next = DW'(sd[W:0]);
      den_next    = in_den << 2;
    end
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      out_ctl    <= in_ctl;
      out_q_re   <= q_re_next;
      out_q_im   <= q_im_next;
      out_rem_re <= rem_re_next;
      out_rem_im <= rem_im_next;
      out_den    <= den_next;
    end
  end

endmodule

// File: rtl/complex_arithmetic_unit_core.sv
// Complex-number ALU on signed fixed point, fully pipelined.
// Depends on cau_pkg and cau_step.
//
//  channel | signals                              | dir
//  --------+--------------------------------------+-----
//  in      | in_valid in_ready cmd a_re a_im b_re b_im | in
//  out     | out_valid out_ready res_re res_im flag status | out
//
// Stages in order: multiply, sum, abs, prescale, DATA_WIDTH+1 quotient/root steps,
// output register. One request per cycle unless out_ready stalls the pipeline.
// Each stage holds its data while the next is full; bubbles are squeezed out.
// Reset clears only the valid bits.
module complex_arithmetic_unit_core #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [3:0]                    cmd,
  input  logic signed [DATA_WIDTH-1:0]  a_re,
  input  logic signed [DATA_WIDTH-1:0]  a_im,
  input  logic signed [DATA_WIDTH-1:0]  b_re,
  input  logic signed [DATA_WIDTH-1:0]  b_im,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [DATA_WIDTH-1:0]  res_re,
  output logic signed [DATA_WIDTH-1:0]  res_im,
  output logic                          flag,
  output logic [1:0]                    status
);
  import cau_pkg::*;

  localparam int W  = DATA_WIDTH;
  localparam int QW = DATA_WIDTH + 1;
  localparam int DW = 2 * DATA_WIDTH;
  localparam int SW = 2 * DATA_WIDTH + 1;
  localparam int NW = 2 * DATA_WIDTH + FRAC_BITS;
  localparam logic [DW:0]   HALF = (FRAC_BITS == 0) ? '0 : (SW'(1) << (FRAC_BITS - 1));
  localparam logic [QW-1:0] LIM  = QW'(1) << (W - 1);
  localparam logic signed [W:0] ONE = QW'(1) << FRAC_BITS;

  // ---------------- stage 1: products and simple ops ----------------
  logic adv1, adv2, adv3, adv4, adv_out;
  logic v1, v2, v3, v4;

  logic [3:0]              c1;
  logic signed [DW-1:0]    p_rr, p_ii, p_ri, p_ir, sq_x, sq_y;
  logic signed [W:0]       sv_re1, sv_im1;
  logic signed [W-1:0]     ar1, ai1, br1;
  logic                    flag1;

  logic signed [W:0]       xa_re, xa_im, xb_re, xb_im, sv_re, sv_im;
  logic signed [W-1:0]     sq_a, sq_b;
  logic                    same;

  always_comb begin
    xa_re = {a_re[W-1], a_re};
    xa_im = {a_im[W-1], a_im};
    xb_re = {b_re[W-1], b_re};
    xb_im = {b_im[W-1], b_im};
    sv_re = '0;
    sv_im = '0;
    case (cmd)
      CMD_ADD:  begin sv_re = xa_re + xb_re; sv_im = xa_im + xb_im; end
      CMD_SUB:  begin sv_re = xa_re - xb_re; sv_im = xa_im - xb_im; end
      CMD_NEG:  begin sv_re = -xa_re;        sv_im = -xa_im;        end
      CMD_INC:  begin sv_re = xa_re + ONE;   sv_im = xa_im;         end
      CMD_DEC:  begin sv_re = xa_re - ONE;   sv_im = xa_im;         end
      CMD_PASS: begin sv_re = xa_re;         sv_im = xa_im;         end
      default:  begin sv_re = '0;            sv_im = '0;            end
    endcase
    same = (a_re == b_re) && (a_im == b_im);
    sq_a = (cmd == CMD_MAG) ? a_re : b_re;
    sq_b = (cmd == CMD_MAG) ? a_im : b_im;
  end

  assign in_ready = adv1;
  assign adv1 = !v1 || adv2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (adv1) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      c1     <= cmd;
      p_rr   <= a_re * b_re;
      p_ii   <= a_im * b_im;
      p_ri   <= a_re * b_im;
      p_ir   <= a_im * b_re;
      sq_x   <= sq_a * sq_a;
      sq_y   <= sq_b * sq_b;
      sv_re1 <= sv_re;
      sv_im1 <= sv_im;
      ar1    <= a_re;
      ai1    <= a_im;
      br1    <= b_re;
      flag1  <= (cmd == CMD_EQ) ? same : ((cmd == CMD_NE) ? !same : 1'b0);
    end
  end

  // ---------------- stage 2: sums, divisor ----------------
  logic [3:0]           c2;
  logic signed [SW-1:0] n_re2, n_im2;
  logic [DW-1:0]        den2;
  logic                 dneg2, flag2;

  logic signed [SW-1:0] n_re, n_im;
  logic [DW-1:0]        den;
  logic signed [W-1:0]  abs_br;

  always_comb begin
    n_re   = SW'(sv_re1);
    n_im   = SW'(sv_im1);
    den    = $unsigned(sq_x) + $unsigned(sq_y);
    abs_br = br1[W-1] ? -br1 : br1;
    case (c1)
      CMD_MUL: begin
        n_re = SW'(p_rr) - SW'(p_ii);
        n_im = SW'(p_ri) + SW'(p_ir);
      end
      CMD_DIV: begin
        n_re = SW'(p_rr) + SW'(p_ii);
        n_im = SW'(p_ir) - SW'(p_ri);
      end
      CMD_DIVS: begin
        n_re = SW'(ar1);
        n_im = SW'(ai1);
        // most negative value negates to itself; take it as unsigned
        den  = DW'($unsigned(abs_br));
      end
      default: ;
    endcase
  end

  assign adv2 = !v2 || adv3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (adv2) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv2) begin
      c2    <= c1;
      n_re2 <= n_re;
      n_im2 <= n_im;
      den2  <= den;
      dneg2 <= (c1 == CMD_DIVS) && br1[W-1];
      flag2 <= flag1;
    end
  end

  // ---------------- stage 3: sign and magnitude ----------------
  ctl_t           ctl3;
  logic [DW-1:0]  m_re3, m_im3, den3;
  logic signed [SW-1:0] neg_re, neg_im;

  always_comb begin
    neg_re = -n_re2;
    neg_im = -n_im2;
  end

  assign adv3 = !v3 || adv4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (adv3) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv3) begin
      ctl3.cmd     <= c2;
      ctl3.sign_re <= n_re2[SW-1] ^ dneg2;
      ctl3.sign_im <= n_im2[SW-1] ^ dneg2;
      ctl3.ovf_re  <= 1'b0;
      ctl3.ovf_im  <= 1'b0;
      ctl3.flag    <= flag2;
      ctl3.dz      <= (c2 == CMD_DIV || c2 == CMD_DIVS) && (den2 == '0);
      m_re3        <= n_re2[SW-1] ? neg_re[DW-1:0] : n_re2[DW-1:0];
      m_im3        <= n_im2[SW-1] ? neg_im[DW-1:0] : n_im2[DW-1:0];
      den3         <= den2;
    end
  end

  // ---------------- stage 4: rounding, prescale, range check ----------------
  ctl_t           ctl4, ctl4_next;
  logic [QW-1:0]  q_re4, q_im4, q_re4_next, q_im4_next;
  logic [DW-1:0]  rem_re4, rem_im4, den4, rem_re4_next, rem_im4_next;
  logic [DW:0]    rnd_re, rnd_im;
  logic [NW-1:0]  nn_re, nn_im;
  logic [DW-1:0]  top_re, top_im;

  always_comb begin
    ctl4_next    = ctl3;
    rnd_re       = ({1'b0, m_re3} + HALF) >> FRAC_BITS;
    rnd_im       = ({1'b0, m_im3} + HALF) >> FRAC_BITS;
    nn_re        = NW'(m_re3) << FRAC_BITS;
    nn_im        = NW'(m_im3) << FRAC_BITS;
    top_re       = DW'(nn_re[NW-1:QW]);
    top_im       = DW'(nn_im[NW-1:QW]);
    q_re4_next   = m_re3[QW-1:0];
    q_im4_next   = m_im3[QW-1:0];
    rem_re4_next = '0;
    rem_im4_next = '0;
    case (ctl3.cmd)
      CMD_MUL: begin
        q_re4_next       = rnd_re[QW-1:0];
        q_im4_next       = rnd_im[QW-1:0];
        ctl4_next.ovf_re = |(rnd_re >> QW);
        ctl4_next.ovf_im = |(rnd_im >> QW);
      end
      CMD_DIV, CMD_DIVS: begin
        q_re4_next       = nn_re[QW-1:0];
        q_im4_next       = nn_im[QW-1:0];
        rem_re4_next     = top_re;
        rem_im4_next     = top_im;
        ctl4_next.ovf_re = top_re >= den3;
        ctl4_next.ovf_im = top_im >= den3;
      end
      CMD_MAG: begin
        q_re4_next        = '0;
        q_im4_next        = '0;
        ctl4_next.sign_re = 1'b0;
        ctl4_next.sign_im = 1'b0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (adv4) begin
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (adv4) begin
      ctl4    <= ctl4_next;
      q_re4   <= q_re4_next;
      q_im4   <= q_im4_next;
      rem_re4 <= rem_re4_next;
      rem_im4 <= rem_im4_next;
      den4    <= den3;
    end
  end

  // ---------------- quotient / root steps ----------------
  logic           lv   [QW+1];
  logic           lr   [QW+1];
  ctl_t           lctl [QW+1];
  logic [QW-1:0]  lq_re [QW+1];
  logic [QW-1:0]  lq_im [QW+1];
  logic [DW-1:0]  lrem_re [QW+1];
  logic [DW-1:0]  lrem_im [QW+1];
  logic [DW-1:0]  lden [QW+1];

  assign adv4 = !v4 || lr[0];

  assign lv[0]      = v4;
  assign lctl[0]    = ctl4;
  assign lq_re[0]   = q_re4;
  assign lq_im[0]   = q_im4;
  assign lrem_re[0] = rem_re4;
  assign lrem_im[0] = rem_im4;
  assign lden[0]    = den4;
  assign lr[QW]     = adv_out;

  for (genvar j = 0; j < QW; j++) begin : g_step
    cau_step #(
      .DATA_WIDTH(DATA_WIDTH),
      .STEP      (j)
    ) u_step (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (lv[j]),
      .in_ready  (lr[j]),
      .in_ctl    (lctl[j]),
      .in_q_re   (lq_re[j]),
      .in_q_im   (lq_im[j]),
      .in_rem_re (lrem_re[j]),
      .in_rem_im (lrem_im[j]),
      .in_den    (lden[j]),
      .out_valid (lv[j+1]),
      .out_ready (lr[j+1]),
      .out_ctl   (lctl[j+1]),
      .out_q_re  (lq_re[j+1]),
      .out_q_im  (lq_im[j+1]),
      .out_rem_re(lrem_re[j+1]),
      .out_rem_im(lrem_im[j+1]),
      .out_den   (lden[j+1])
    );
  end

  // ---------------- saturation and output register ----------------
  function automatic logic [W:0] sat_fn(input logic neg, input logic [QW-1:0] m,
                                        input logic ovf);
    logic [QW-1:0] mn;
    logic [W:0]    r;
    mn = ~m + QW'(1);
    if (ovf || m > LIM || (!neg && m == LIM)) begin
      r = {1'b1, (neg ? LIM[W-1:0] : LIM[W-1:0] - W'(1))};
    end else begin
      r = {1'b0, (neg ? mn[W-1:0] : m[W-1:0])};
    end
    return r;
  endfunction

  ctl_t       fctl;
  logic [W:0] f_re, f_im;
  logic [W-1:0] re_next, im_next;
  logic [1:0] status_next;

  always_comb begin
    fctl        = lctl[QW];
    f_re        = sat_fn(fctl.sign_re, lq_re[QW], fctl.ovf_re);
    f_im        = sat_fn(fctl.sign_im, lq_im[QW], fctl.ovf_im);
    re_next     = f_re[W-1:0];
    im_next     = f_im[W-1:0];
    status_next = (f_re[W] || f_im[W]) ? ST_SAT : ST_OK;
    if (fctl.dz) begin
      re_next     = '0;
      im_next     = '0;
      status_next = ST_DZ;
    end
  end

  assign adv_out = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv_out) begin
      out_valid <= lv[QW];
    end
  end

  always_ff @(posedge clk) begin
    if (adv_out) begin
      res_re <= re_next;
      res_im <= im_next;
      flag   <= fctl.flag;
      status <= status_next;
    end
  end

endmodule
